### rtl/core/gmdfs_pkg.sv
package gmdfs_pkg;

	// Default grid bounds.
	localparam int MAX_ROWS_DEF    = 64;
	localparam int MAX_COLUMNS_DEF = 64;

	// Field and register widths.
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int OP_W      = 2;
	localparam int KIND_W    = 2;
	localparam int POS_W     = 6;
	localparam int STATUS_W  = 2;
	localparam int DIR_W     = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS    = 1'd0,
		REG_COLUMNS = 1'd1
	} reg_idx_t;

	// Operations carried by an input item.
	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_STEP  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Cell codes held in the grid memory.
	typedef enum logic [2:0] {
		KIND_WALL  = 3'd0,
		KIND_OPEN  = 3'd1,
		KIND_START = 3'd2,
		KIND_EXIT  = 3'd3,
		KIND_SEEN  = 3'd4
	} kind_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		SS_VISIT    = 2'd0,
		SS_EXIT     = 2'd1,
		SS_NONE     = 2'd2,
		SS_FINISHED = 2'd3
	} status_t;

	// Search phase.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN  = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	// Neighbor order: left, right, up, down, then exhausted.
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
	localparam logic [DIR_W-1:0] DIR_UP    = 3'd2;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd3;
	localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

	// Controller states.
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LD_DIV,
		S_SCAN,
		S_SCAN_CHK,
		S_ADV,
		S_ADV_CHK,
		S_POP,
		S_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    clr_start;
		logic    clr_step;
		logic    ld_start;
		logic    div_step;
		logic    ld_write;
		logic    scan_start;
		logic    scan_read;
		logic    scan_next;
		logic    scan_hit;
		logic    adv_try;
		logic    adv_push;
		logic    pop;
		logic    pop_load;
		logic    out_load;
		logic    out_zero;
		status_t out_status;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic  clr_last;
		logic  ld_room;
		logic  div_done;
		logic  depth_zero;
		logic  pop_to_zero;
		logic  top_done;
		logic  nb_off;
		logic  scan_last;
		kind_t grid_kind;
	} dp_sts_t;

endpackage

### rtl/core/gmdfs_in_if.sv
interface gmdfs_in_if;
	logic                          valid;
	logic                          ready;
	logic [gmdfs_pkg::OP_W-1:0]    operation;
	logic [gmdfs_pkg::KIND_W-1:0]  cell_kind;

	modport source (output valid, output operation, output cell_kind, input ready);
	modport sink (input valid, input operation, input cell_kind, output ready);
endinterface

### rtl/core/gmdfs_out_if.sv
interface gmdfs_out_if;
	logic                           valid;
	logic                           ready;
	logic [gmdfs_pkg::POS_W-1:0]    cell_row;
	logic [gmdfs_pkg::POS_W-1:0]    cell_column;
	logic [gmdfs_pkg::STATUS_W-1:0] search_status;

	modport source (output valid, output cell_row, output cell_column, output search_status,
		input ready);
	modport sink (input valid, input cell_row, input cell_column, input search_status,
		output ready);
endinterface

### rtl/core/gmdfs_dp.sv
module gmdfs_dp #(
	parameter int MAX_ROWS    = gmdfs_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = gmdfs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gmdfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gmdfs_pkg::CFG_W-1:0]    cfg_data,
	input  logic [gmdfs_pkg::KIND_W-1:0]   kind_in,
	input  gmdfs_pkg::dp_cmd_t             cmd,
	output gmdfs_pkg::dp_sts_t             sts,
	output logic [gmdfs_pkg::POS_W-1:0]    cell_row,
	output logic [gmdfs_pkg::POS_W-1:0]    cell_column,
	output logic [gmdfs_pkg::STATUS_W-1:0] search_status
);
	import gmdfs_pkg::*;

	localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLUMNS);
	localparam int DW    = $clog2(CELLS + 1);
	localparam int MW    = (RW > CW) ? RW : CW;
	localparam int XW    = ((MW > CFG_W) ? MW : CFG_W) + 1;
	localparam int PW    = (DW > 2 * CFG_W) ? DW : 2 * CFG_W;
	localparam int SW    = RW + CW + DIR_W;
	localparam int NW    = $clog2(DW + 1);

	// Grid address of a row and column.
	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
		int a;
		a = int'(r) * MAX_COLUMNS + int'(c);
		return AW'(a);
	endfunction

	logic [CFG_W-1:0] rows_cfg_q, cols_cfg_q;
	logic [CFG_W-1:0] rows_eff, cols_eff;
	logic [AW-1:0]    clr_addr_q;
	logic [DW-1:0]    load_cnt_q, depth_q;
	logic [NW-1:0]    div_cnt_q;
	logic [CFG_W-1:0] div_rem_q;
	logic [DW-1:0]    div_quo_q;
	logic [KIND_W-1:0] kind_q;
	logic [RW-1:0]    top_row_q, nb_row_q;
	logic [CW-1:0]    top_col_q, nb_col_q;
	logic [DIR_W-1:0] top_dir_q;
	kind_t            grid_rd_q;
	logic [SW-1:0]    stk_rd_q;
	logic [POS_W-1:0] row_out_q, col_out_q;
	status_t          status_out_q;

	kind_t            grid_mem [CELLS];
	logic [SW-1:0]    stk_mem [CELLS];

	logic [XW-1:0]    top_r_x, top_c_x, nr_x, nc_x, scan_r1_x, scan_c1_x;
	logic             edge_skip, col_wrap;
	logic [AW-1:0]    nb_addr, scan_addr, g_waddr, g_raddr;
	kind_t            g_wdata;
	logic             g_we, g_re;
	logic [CFG_W:0]   rem_sh, rem_sub;
	logic             quo_bit;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= CFG_W'(1);
			cols_cfg_q <= CFG_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_ROWS) begin
				rows_cfg_q <= cfg_data;
			end else if (cfg_index == REG_COLUMNS) begin
				cols_cfg_q <= cfg_data;
			end
		end
	end

	// Clamp the dimensions to the grid bounds.
	always_comb begin
		if (rows_cfg_q == '0) begin
			rows_eff = CFG_W'(1);
		end else if (int'(rows_cfg_q) > MAX_ROWS) begin
			rows_eff = CFG_W'(MAX_ROWS);
		end else begin
			rows_eff = rows_cfg_q;
		end
		if (cols_cfg_q == '0) begin
			cols_eff = CFG_W'(1);
		end else if (int'(cols_cfg_q) > MAX_COLUMNS) begin
			cols_eff = CFG_W'(MAX_COLUMNS);
		end else begin
			cols_eff = cols_cfg_q;
		end
	end

	// Neighbor of the top cell in its current direction.
	always_comb begin
		top_r_x   = XW'(top_row_q);
		top_c_x   = XW'(top_col_q);
		nr_x      = top_r_x;
		nc_x      = top_c_x;
		edge_skip = 1'b0;
		unique case (top_dir_q)
			DIR_LEFT: begin
				if (top_col_q == '0) edge_skip = 1'b1;
				else nc_x = top_c_x - XW'(1);
			end
			DIR_RIGHT: nc_x = top_c_x + XW'(1);
			DIR_UP: begin
				if (top_row_q == '0) edge_skip = 1'b1;
				else nr_x = top_r_x - XW'(1);
			end
			DIR_DOWN: nr_x = top_r_x + XW'(1);
			default: edge_skip = 1'b1;
		endcase
	end

	assign nb_addr   = cell_addr(RW'(nr_x), CW'(nc_x));
	assign scan_addr = cell_addr(nb_row_q, nb_col_q);
	assign scan_r1_x = XW'(nb_row_q) + XW'(1);
	assign scan_c1_x = XW'(nb_col_q) + XW'(1);
	assign col_wrap  = scan_c1_x >= XW'(cols_eff);

	// One step of the restoring divider that splits the load count.
	assign rem_sh  = {div_rem_q, div_quo_q[DW-1]};
	assign quo_bit = rem_sh >= {1'b0, cols_eff};
	assign rem_sub = quo_bit ? (rem_sh - {1'b0, cols_eff}) : rem_sh;

	// Grid write and read port selection.
	always_comb begin
		g_we    = 1'b1;
		g_waddr = nb_addr;
		g_wdata = KIND_SEEN;
		priority if (cmd.clr_step) begin
			g_waddr = clr_addr_q;
			g_wdata = KIND_WALL;
		end else if (cmd.ld_write) begin
			g_waddr = cell_addr(RW'(div_quo_q), CW'(div_rem_q));
			g_wdata = kind_t'({1'b0, kind_q});
		end else if (cmd.scan_hit || cmd.adv_push) begin
			g_waddr = scan_addr;
		end else begin
			g_we = 1'b0;
		end
		g_re    = cmd.scan_read || cmd.adv_try;
		g_raddr = cmd.scan_read ? scan_addr : nb_addr;
	end

	// Grid memory.
	always_ff @(posedge clk) begin
		if (g_we) grid_mem[g_waddr] <= g_wdata;
		if (g_re) grid_rd_q <= grid_mem[g_raddr];
	end

	// Stack memory: holds every frame below the top one.
	always_ff @(posedge clk) begin
		if (cmd.adv_push) stk_mem[AW'(depth_q - DW'(1))] <= {top_row_q, top_col_q, top_dir_q};
		if (cmd.pop) stk_rd_q <= stk_mem[AW'(depth_q - DW'(2))];
	end

	// Counters: clearing sweep, load count, stack depth, divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			load_cnt_q <= '0;
			depth_q    <= '0;
			div_cnt_q  <= '0;
		end else begin
			if (cmd.clr_start) begin
				clr_addr_q <= '0;
				load_cnt_q <= '0;
				depth_q    <= '0;
			end
			if (cmd.clr_step) clr_addr_q <= clr_addr_q + AW'(1);
			if (cmd.ld_write) load_cnt_q <= load_cnt_q + DW'(1);
			if (cmd.ld_start) div_cnt_q <= '0;
			if (cmd.div_step) div_cnt_q <= div_cnt_q + NW'(1);
			if (cmd.scan_hit) depth_q <= DW'(1);
			if (cmd.adv_push) depth_q <= depth_q + DW'(1);
			if (cmd.pop) depth_q <= depth_q - DW'(1);
		end
	end

	// Search registers, divider data and the result item.
	always_ff @(posedge clk) begin
		if (cmd.ld_start) begin
			kind_q    <= kind_in;
			div_rem_q <= '0;
			div_quo_q <= load_cnt_q;
		end
		if (cmd.div_step) begin
			div_rem_q <= CFG_W'(rem_sub);
			div_quo_q <= {div_quo_q[DW-2:0], quo_bit};
		end
		if (cmd.scan_start) begin
			nb_row_q <= '0;
			nb_col_q <= '0;
		end
		if (cmd.scan_next) begin
			if (col_wrap) begin
				nb_col_q <= '0;
				nb_row_q <= RW'(scan_r1_x);
			end else begin
				nb_col_q <= CW'(scan_c1_x);
			end
		end
		if (cmd.adv_try) begin
			nb_row_q  <= RW'(nr_x);
			nb_col_q  <= CW'(nc_x);
			top_dir_q <= top_dir_q + DIR_W'(1);
		end
		if (cmd.scan_hit || cmd.adv_push) begin
			top_row_q <= nb_row_q;
			top_col_q <= nb_col_q;
			top_dir_q <= DIR_LEFT;
		end
		if (cmd.pop_load) {top_row_q, top_col_q, top_dir_q} <= stk_rd_q;
		if (cmd.out_load) begin
			row_out_q    <= cmd.out_zero ? '0 : POS_W'(nb_row_q);
			col_out_q    <= cmd.out_zero ? '0 : POS_W'(nb_col_q);
			status_out_q <= cmd.out_status;
		end
	end

	// Status to the controller.
	always_comb begin
		sts.clr_last    = clr_addr_q == AW'(CELLS - 1);
		sts.ld_room     = PW'(load_cnt_q) < (PW'(rows_eff) * PW'(cols_eff));
		sts.div_done    = div_cnt_q == NW'(DW);
		sts.depth_zero  = depth_q == '0;
		sts.pop_to_zero = depth_q == DW'(1);
		sts.top_done    = top_dir_q >= DIR_DONE;
		sts.nb_off      = edge_skip || (nr_x >= XW'(rows_eff)) || (nc_x >= XW'(cols_eff));
		sts.scan_last   = (scan_r1_x >= XW'(rows_eff)) && col_wrap;
		sts.grid_kind   = grid_rd_q;
	end

	assign cell_row      = row_out_q;
	assign cell_column   = col_out_q;
	assign search_status = status_out_q;
endmodule

### rtl/core/gmdfs_ctrl.sv
module gmdfs_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [gmdfs_pkg::OP_W-1:0] in_operation,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  gmdfs_pkg::dp_sts_t         sts,
	output gmdfs_pkg::dp_cmd_t         cmd
);
	import gmdfs_pkg::*;

	state_t  state_q, state_d;
	phase_t  phase_q, phase_d;
	logic    out_valid_q;
	logic    emit_zero_q, emit_zero_d;
	status_t emit_status_q, emit_status_d;
	logic    accept, slot_free;
	op_t     op;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign op        = op_t'(in_operation);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (sts.clr_last) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_LOAD: if (phase_q == PH_IDLE && sts.ld_room) state_d = S_LD_DIV;
						OP_STEP: begin
							unique case (phase_q)
								PH_IDLE: state_d = S_SCAN;
								PH_RUN:  state_d = S_ADV;
								default: state_d = S_EMIT;
							endcase
						end
						OP_CLEAR: state_d = S_CLEAR;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_LD_DIV: if (sts.div_done) state_d = S_IDLE;
			S_SCAN: state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (sts.grid_kind == KIND_START || sts.scan_last) state_d = S_EMIT;
				else state_d = S_SCAN;
			end
			S_ADV: begin
				priority if (sts.depth_zero) state_d = S_EMIT;
				else if (sts.top_done) state_d = sts.pop_to_zero ? S_ADV : S_POP;
				else if (!sts.nb_off) state_d = S_ADV_CHK;
			end
			S_ADV_CHK: begin
				if (sts.grid_kind == KIND_EXIT || sts.grid_kind == KIND_OPEN) state_d = S_EMIT;
				else state_d = S_ADV;
			end
			S_POP: state_d = S_ADV;
			S_EMIT: if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Commands, phase updates and the pending result.
	always_comb begin
		cmd           = '0;
		cmd.out_status = emit_status_q;
		cmd.out_zero  = emit_zero_q;
		phase_d       = phase_q;
		emit_zero_d   = emit_zero_q;
		emit_status_d = emit_status_q;
		unique case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_LOAD: cmd.ld_start = (phase_q == PH_IDLE) && sts.ld_room;
						OP_STEP: begin
							unique case (phase_q)
								PH_IDLE: cmd.scan_start = 1'b1;
								PH_RUN:  ;
								default: begin
									emit_zero_d   = 1'b1;
									emit_status_d = SS_FINISHED;
								end
							endcase
						end
						OP_CLEAR: begin
							cmd.clr_start = 1'b1;
							phase_d       = PH_IDLE;
						end
						default: ;
					endcase
				end
			end
			S_LD_DIV: begin
				if (sts.div_done) cmd.ld_write = 1'b1;
				else cmd.div_step = 1'b1;
			end
			S_SCAN: cmd.scan_read = 1'b1;
			S_SCAN_CHK: begin
				if (sts.grid_kind == KIND_START) begin
					cmd.scan_hit  = 1'b1;
					phase_d       = PH_RUN;
					emit_zero_d   = 1'b0;
					emit_status_d = SS_VISIT;
				end else if (sts.scan_last) begin
					phase_d       = PH_DONE;
					emit_zero_d   = 1'b1;
					emit_status_d = SS_NONE;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_ADV: begin
				priority if (sts.depth_zero) begin
					phase_d       = PH_DONE;
					emit_zero_d   = 1'b1;
					emit_status_d = SS_NONE;
				end else if (sts.top_done) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.adv_try = 1'b1;
				end
			end
			S_ADV_CHK: begin
				if (sts.grid_kind == KIND_EXIT) begin
					phase_d       = PH_DONE;
					emit_zero_d   = 1'b0;
					emit_status_d = SS_EXIT;
				end else if (sts.grid_kind == KIND_OPEN) begin
					cmd.adv_push  = 1'b1;
					emit_zero_d   = 1'b0;
					emit_status_d = SS_VISIT;
				end
			end
			S_POP: cmd.pop_load = 1'b1;
			S_EMIT: cmd.out_load = slot_free;
			default: ;
		endcase
	end

	// State, phase, pending result and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			phase_q       <= PH_IDLE;
			out_valid_q   <= 1'b0;
			emit_zero_q   <= 1'b1;
			emit_status_q <= SS_NONE;
		end else begin
			state_q       <= state_d;
			phase_q       <= phase_d;
			emit_zero_q   <= emit_zero_d;
			emit_status_q <= emit_status_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
endmodule

### rtl/core/grid_maze_depth_first_search_core.sv
// Load item: the accept, one divider step per load count bit (13 here), then the write.
// Step item: a read and a check per cell scanned for the start, then a read and a check per neighbor read
// from the grid memory, a direction advance per neighbor off the grid, a stack read and load per pop, then the result.
// Clear item and reset: a sweep writes a wall into every grid entry, one per cycle
// (MAX_ROWS * MAX_COLUMNS entries, 4096 by default), and no item is taken until it ends.
// Reset sets both dimension registers to 1 and leaves no result pending.
module grid_maze_depth_first_search_core #(
	parameter int MAX_ROWS    = gmdfs_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = gmdfs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gmdfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gmdfs_pkg::CFG_W-1:0]     cfg_data,
	gmdfs_in_if.sink                        in_ch,
	gmdfs_out_if.source                     out_ch
);
	import gmdfs_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer for loads, clears and the search walk.
	gmdfs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_operation (in_ch.operation),
		.in_ready     (in_ch.ready),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// Grid, stack and result registers.
	gmdfs_dp #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind_in       (in_ch.cell_kind),
		.cmd           (cmd),
		.sts           (sts),
		.cell_row      (out_ch.cell_row),
		.cell_column   (out_ch.cell_column),
		.search_status (out_ch.search_status)
	);
endmodule

### tb/gmdfs_walk_checker.sv
`default_nettype none

module gmdfs_walk_checker
	import gmdfs_pkg::*;
#(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	gmdfs_in_if                  in_ch,
	gmdfs_out_if                 out_ch,
	output int                   fail_count,
	output int                   reports_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS = MAX_ROWS * MAX_COLUMNS;

	typedef struct {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] column;
		status_t          status;
	} cell_report_t;

	// Expected reports, oldest first.
	cell_report_t report_q[$];

	// Shadow copy of the maze and the walk.
	kind_t            grid[CELLS];
	int unsigned      path_row[CELLS];
	int unsigned      path_col[CELLS];
	logic [DIR_W-1:0] path_dir[CELLS];
	int unsigned      path_depth;
	int unsigned      loaded;
	phase_t           phase;
	logic [CFG_W-1:0] rows_reg;
	logic [CFG_W-1:0] cols_reg;

	function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	function automatic void wipe_maze();
		foreach (grid[i])
			grid[i] = KIND_WALL;
		path_depth = 0;
		loaded = 0;
		phase = PH_IDLE;
	endfunction

	function automatic void expect_report(int unsigned r, int unsigned c, status_t st);
		cell_report_t rep;
		rep.row = r[POS_W-1:0];
		rep.column = c[POS_W-1:0];
		rep.status = st;
		report_q.push_back(rep);
	endfunction

	function automatic void enter_cell(int unsigned r, int unsigned c);
		grid[r * MAX_COLUMNS + c] = KIND_SEEN;
		path_row[path_depth] = r;
		path_col[path_depth] = c;
		path_dir[path_depth] = DIR_LEFT;
		path_depth++;
	endfunction

	// One step request: find the start, or walk on to the next new cell.
	function automatic void walk_step();
		int unsigned rows;
		int unsigned cols;
		int unsigned r;
		int unsigned c;
		int unsigned nr;
		int unsigned nc;
		logic [DIR_W-1:0] d;
		kind_t k;
		rows = clamp_dim(rows_reg, MAX_ROWS);
		cols = clamp_dim(cols_reg, MAX_COLUMNS);
		if (phase == PH_IDLE) begin
			for (int unsigned i = 0; i < rows; i++) begin
				for (int unsigned j = 0; j < cols; j++) begin
					if (grid[i * MAX_COLUMNS + j] == KIND_START) begin
						path_depth = 0;
						enter_cell(i, j);
						phase = PH_RUN;
						expect_report(i, j, SS_VISIT);
						return;
					end
				end
			end
			phase = PH_DONE;
			expect_report(0, 0, SS_NONE);
			return;
		end
		if (phase == PH_DONE) begin
			expect_report(0, 0, SS_FINISHED);
			return;
		end
		while (path_depth > 0) begin
			d = path_dir[path_depth - 1];
			if (d >= DIR_DONE) begin
				path_depth--;
				continue;
			end
			r = path_row[path_depth - 1];
			c = path_col[path_depth - 1];
			path_dir[path_depth - 1] = d + DIR_W'(1);
			nr = r;
			nc = c;
			if (d == DIR_LEFT) begin
				if (c == 0)
					continue;
				nc = c - 1;
			end else if (d == DIR_RIGHT) begin
				nc = c + 1;
			end else if (d == DIR_UP) begin
				if (r == 0)
					continue;
				nr = r - 1;
			end else begin
				nr = r + 1;
			end
			if (nr >= rows || nc >= cols)
				continue;
			k = grid[nr * MAX_COLUMNS + nc];
			if (k == KIND_EXIT) begin
				phase = PH_DONE;
				expect_report(nr, nc, SS_EXIT);
				return;
			end
			if (k == KIND_OPEN) begin
				enter_cell(nr, nc);
				expect_report(nr, nc, SS_VISIT);
				return;
			end
		end
		phase = PH_DONE;
		expect_report(0, 0, SS_NONE);
	endfunction

	function automatic void take_item(op_t op, logic [KIND_W-1:0] kind);
		int unsigned cols;
		cols = clamp_dim(cols_reg, MAX_COLUMNS);
		case (op)
			OP_LOAD: begin
				if (phase == PH_IDLE && loaded < clamp_dim(rows_reg, MAX_ROWS) * cols) begin
					grid[(loaded / cols) * MAX_COLUMNS + loaded % cols] = kind_t'({1'b0, kind});
					loaded++;
				end
			end
			OP_STEP: walk_step();
			OP_CLEAR: wipe_maze();
			default: ;
		endcase
	endfunction

	// Snoop writes and items at each edge, compare reports in arrival order.
	always @(posedge clk or negedge arst_n) begin
		cell_report_t want;
		if (!arst_n) begin
			rows_reg = CFG_W'(1);
			cols_reg = CFG_W'(1);
			wipe_maze();
			report_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ROWS)
					rows_reg = cfg_data;
				else
					cols_reg = cfg_data;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (report_q.size() == 0) begin
					$error("unexpected report row=%0d column=%0d status=%0d",
						out_ch.cell_row, out_ch.cell_column, out_ch.search_status);
					fail_count++;
				end else begin
					want = report_q.pop_front();
					if (out_ch.cell_row !== want.row) begin
						$error("cell_row: expected %0d, got %0d", want.row, out_ch.cell_row);
						fail_count++;
					end
					if (out_ch.cell_column !== want.column) begin
						$error("cell_column: expected %0d, got %0d",
							want.column, out_ch.cell_column);
						fail_count++;
					end
					if (out_ch.search_status !== want.status) begin
						$error("search_status: expected %0d, got %0d",
							want.status, out_ch.search_status);
						fail_count++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				take_item(op_t'(in_ch.operation), in_ch.cell_kind);
		end
		reports_owed = report_q.size();
	end

endmodule

`default_nettype wire

### tb/tb_grid_maze_depth_first_search_core.sv
`default_nettype none

module tb_grid_maze_depth_first_search_core;
	timeunit 1ns;
	timeprecision 1ps;
	import gmdfs_pkg::*;

	localparam int ITEM_GOAL   = 1550;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE      = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count;
	int                   reports_owed;
	int                   items_sent;
	int                   cycles;
	int                   send_calm;
	int                   take_calm;
	int                   take_stall;

	gmdfs_in_if  in_ch();
	gmdfs_out_if out_ch();

	grid_maze_depth_first_search_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	gmdfs_walk_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.fail_count  (fail_count),
		.reports_owed(reports_owed)
	);

	always #5 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: calm stretches, short stalls and a few long ones.
	always @(posedge clk) begin
		if (take_stall > 0) begin
			out_ch.ready <= 1'b0;
			take_stall <= take_stall - 1;
		end else if (take_calm > 0) begin
			out_ch.ready <= 1'b1;
			take_calm <= take_calm - 1;
		end else begin
			out_ch.ready <= 1'b1;
			case ($urandom_range(0, 99)) inside
				[0:3]:   take_calm <= $urandom_range(100, 400);
				[4:23]:  take_stall <= $urandom_range(1, 3);
				[24:28]: take_stall <= $urandom_range(15, 60);
				default: ;
			endcase
		end
	end

	function automatic int sender_gap();
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		case ($urandom_range(0, 99)) inside
			[0:2]:   begin send_calm = $urandom_range(50, 200); return 0; end
			[3:27]:  return $urandom_range(1, 3);
			[28:33]: return $urandom_range(15, 60);
			default: return 0;
		endcase
	endfunction

	// Present one item; returns on the edge at which it is taken.
	task automatic send_item(op_t op, logic [KIND_W-1:0] kind);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.cell_kind <= kind;
		@(negedge clk);
		while (!in_ch.ready)
			@(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	// Hold off until every expected report has come and the block is quiet.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (reports_owed != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd127;
			2: return 7'd64;
			3: return CFG_W'($urandom_range(0, 127));
			default: return CFG_W'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] random_cell();
		case ($urandom_range(0, 99)) inside
			[0:57]:  return KIND_OPEN[KIND_W-1:0];
			[58:89]: return KIND_WALL[KIND_W-1:0];
			[90:94]: return KIND_EXIT[KIND_W-1:0];
			default: return KIND_START[KIND_W-1:0];
		endcase
	endfunction

	// One maze: set its size, clear, load, then walk it with some noise.
	task automatic run_maze();
		logic [CFG_W-1:0] rows_v;
		logic [CFG_W-1:0] cols_v;
		int eff_r;
		int eff_c;
		int n_load;
		int start_at;
		int n_step;
		rows_v = pick_dim();
		cols_v = pick_dim();
		if ($urandom_range(0, 4) == 0) begin
			// Long strip reaching the last row or column.
			rows_v = $urandom_range(0, 1) ? 7'd64 : 7'd1;
			cols_v = (rows_v == 7'd1) ? 7'd64 : 7'd1;
		end
		eff_r = (rows_v == 0) ? 1 : (rows_v > 64 ? 64 : int'(rows_v));
		eff_c = (cols_v == 0) ? 1 : (cols_v > 64 ? 64 : int'(cols_v));
		n_load = eff_r * eff_c;
		if (n_load > 64)
			n_load = $urandom_range(10, 70);
		drain();
		write_reg(REG_ROWS, rows_v);
		write_reg(REG_COLUMNS, cols_v);
		send_item(OP_CLEAR, KIND_W'($urandom_range(0, 3)));
		start_at = ($urandom_range(0, 9) == 0) ? -1 : int'($urandom_range(0, n_load - 1));
		if ($urandom_range(0, 9) == 0)
			n_load += $urandom_range(1, 3);
		for (int i = 0; i < n_load; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(OP_NONE, KIND_W'($urandom_range(0, 3)));
			send_item(OP_LOAD, (i == start_at) ? KIND_START[KIND_W-1:0] : random_cell());
		end
		if ($urandom_range(0, 9) == 0) begin
			// Change a dimension between loading and walking.
			drain();
			if ($urandom_range(0, 1))
				write_reg(REG_ROWS, pick_dim());
			else
				write_reg(REG_COLUMNS, pick_dim());
		end
		n_step = n_load + $urandom_range(1, 3);
		for (int i = 0; i < n_step; i++) begin
			case ($urandom_range(0, 49)) inside
				[0:2]: send_item(OP_LOAD, KIND_W'($urandom_range(0, 3)));
				3:     send_item(OP_NONE, KIND_W'($urandom_range(0, 3)));
				4:     if (i > 2) send_item(OP_CLEAR, KIND_W'($urandom_range(0, 3)));
				default: ;
			endcase
			send_item(OP_STEP, KIND_W'($urandom_range(0, 3)));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_NONE;
		in_ch.cell_kind = '0;
		out_ch.ready = 1'b0;
		items_sent = 0;
		cycles = 0;
		send_calm = 0;
		take_calm = 0;
		take_stall = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One-cell grid after reset: no start, then finished, ignored code.
		send_item(OP_STEP, 2'd0);
		send_item(OP_STEP, 2'd3);
		send_item(OP_NONE, 2'd3);
		// Lone start cell; a load past the grid and one after the walk began.
		send_item(OP_CLEAR, 2'd0);
		send_item(OP_LOAD, KIND_START[KIND_W-1:0]);
		send_item(OP_LOAD, KIND_OPEN[KIND_W-1:0]);
		send_item(OP_STEP, 2'd1);
		send_item(OP_LOAD, KIND_EXIT[KIND_W-1:0]);
		send_item(OP_STEP, 2'd2);
		send_item(OP_STEP, 2'd0);

		// Two by three with a second start acting as a wall, exit reached.
		drain();
		write_reg(REG_ROWS, 7'd2);
		write_reg(REG_COLUMNS, 7'd3);
		send_item(OP_CLEAR, 2'd3);
		send_item(OP_LOAD, KIND_OPEN[KIND_W-1:0]);
		send_item(OP_LOAD, KIND_START[KIND_W-1:0]);
		send_item(OP_LOAD, KIND_START[KIND_W-1:0]);
		send_item(OP_LOAD, KIND_EXIT[KIND_W-1:0]);
		send_item(OP_LOAD, KIND_OPEN[KIND_W-1:0]);
		send_item(OP_LOAD, KIND_WALL[KIND_W-1:0]);
		repeat (4) send_item(OP_STEP, 2'd0);

		while (items_sent < ITEM_GOAL)
			run_maze();

		drain();
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
